### hdl/slcf_pkg.sv
// ---------------------------------------------------------------------------
// slcf_pkg: shared types and constants of the sync/length/checksum framer
// Holds the item operation codes, the sync byte values and the result group
// that one accepted item turns into.
// ---------------------------------------------------------------------------
package slcf_pkg;

    // Operation carried on the slave-side tuser bit.
    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Most words that a single item can produce (header plus checksum).
    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // One output word as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } entry_t;

    // All words produced by one accepted item, entry 0 goes out first.
    typedef struct packed {
        entry_t [MAX_RESULTS-1:0] ent;
        logic   [CNT_W-1:0]       cnt;
    } group_t;

    // Two's complement of the running sum, modulo 256.
    function automatic logic [BYTE_W-1:0] checksum_of(input logic [BYTE_W-1:0] sum);
        return (~sum) + BYTE_W'(1);
    endfunction

endpackage

### hdl/slcf_frame_ctl.sv
// ---------------------------------------------------------------------------
// slcf_frame_ctl: frame state and result group builder
// Keeps the open-frame flag, the remaining payload count and the running
// sum, and turns the item at the input into the group of words it causes.
// ---------------------------------------------------------------------------
module slcf_frame_ctl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_accept,
    input  slcf_pkg::op_t             item_op,
    input  logic [7:0]                item_cmd,
    input  logic [15:0]               item_plen,
    input  logic [7:0]                item_pbyte,
    output slcf_pkg::group_t          group
);
    import slcf_pkg::*;

    logic              frame_open_reg, frame_open_next;
    logic [LEN_W-1:0]  remaining_reg,  remaining_next;
    logic [BYTE_W-1:0] sum_reg,        sum_next;

    // Build the group and the next frame state for the presented item.
    always_comb begin
        logic [LEN_W-1:0]  len_val;
        logic [BYTE_W-1:0] hdr_sum;
        logic [BYTE_W-1:0] pay_sum;
        logic [LEN_W-1:0]  rem_dec;

        len_val = item_plen + LEN_W'(1);
        hdr_sum = len_val[15:8] + len_val[7:0] + item_cmd;
        pay_sum = sum_reg + item_pbyte;
        rem_dec = remaining_reg - LEN_W'(1);

        group           = '0;
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        sum_next        = sum_reg;

        case (item_op)
            OP_START: begin
                group.ent[0] = '{data: SYNC_FIRST,    last: 1'b0, err: frame_open_reg};
                group.ent[1] = '{data: SYNC_SECOND,   last: 1'b0, err: 1'b0};
                group.ent[2] = '{data: len_val[15:8], last: 1'b0, err: 1'b0};
                group.ent[3] = '{data: len_val[7:0],  last: 1'b0, err: 1'b0};
                group.ent[4] = '{data: item_cmd,      last: 1'b0, err: 1'b0};
                remaining_next = item_plen;
                if (item_plen == '0) begin
                    // Empty payload: the checksum closes the frame at once.
                    group.ent[5]    = '{data: checksum_of(hdr_sum), last: 1'b1, err: 1'b0};
                    group.cnt       = CNT_W'(6);
                    frame_open_next = 1'b0;
                    sum_next        = '0;
                end else begin
                    group.cnt       = CNT_W'(5);
                    frame_open_next = 1'b1;
                    sum_next        = hdr_sum;
                end
            end
            OP_PAYLOAD: begin
                if (!frame_open_reg) begin
                    // Stray payload byte outside any frame.
                    group.ent[0] = '{data: '0, last: 1'b0, err: 1'b1};
                    group.cnt    = CNT_W'(1);
                end else begin
                    group.ent[0]   = '{data: item_pbyte, last: 1'b0, err: 1'b0};
                    remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        group.ent[1]    = '{data: checksum_of(pay_sum), last: 1'b1, err: 1'b0};
                        group.cnt       = CNT_W'(2);
                        frame_open_next = 1'b0;
                        sum_next        = '0;
                    end else begin
                        group.cnt = CNT_W'(1);
                        sum_next  = pay_sum;
                    end
                end
            end
            default: begin
                group = '0;
            end
        endcase
    end

    // Frame state advances only when an item is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= '0;
            sum_reg        <= '0;
        end else if (item_accept) begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
            sum_reg        <= sum_next;
        end
    end

endmodule

### hdl/sync_length_checksum_framer_top.sv
// ---------------------------------------------------------------------------
// sync_length_checksum_framer_top: byte framer with sync, length and checksum
// Start items emit a five-byte header, payload items pass their byte or,
// outside a frame, an error word, and the checksum byte ends each frame.
// ---------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit first)              | tlast      | tuser
//  s_       | in        | command, payload_length, payload_byte | -       | operation
//  m_       | out       | out_byte                           | frame_last | error
//
//  Each accepted item is loaded into the group register: a payload item
//  gives one word, the payload byte that closes a frame two, a start
//  item five, a start with empty payload six. The single output word
//  register moves one word per cycle out of the group register while m_
//  is not stalled. Reset is synchronous and clears the frame state and
//  both valid flags; a stall on m_ holds the words in place and backs up
//  into s_tready once the group register is occupied.
// ---------------------------------------------------------------------------
module sync_length_checksum_framer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[7:0], payload_length[23:8], payload_byte[31:24]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser    // error
);
    import slcf_pkg::*;

    logic   s_accept;
    group_t new_group;

    entry_t [MAX_RESULTS-1:0] ent_reg, ent_next;
    logic   [CNT_W-1:0]       cnt_reg, cnt_next;

    logic   out_valid_reg, out_valid_next;
    entry_t out_reg, out_next;

    logic grp_valid;
    logic out_free;
    logic move;
    logic grp_done;

    // Handshake: a new item enters when the group register is empty or drains this cycle.
    assign grp_valid = (cnt_reg != '0);
    assign out_free  = !out_valid_reg || m_tready;
    assign move      = grp_valid && out_free;
    assign grp_done  = move && (cnt_reg == CNT_W'(1));
    assign s_tready  = !grp_valid || grp_done;
    assign s_accept  = s_tvalid && s_tready;

    slcf_frame_ctl u_frame_ctl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (s_accept),
        .item_op     (op_t'(s_tuser)),
        .item_cmd    (s_tdata[7:0]),
        .item_plen   (s_tdata[23:8]),
        .item_pbyte  (s_tdata[31:24]),
        .group       (new_group)
    );

    // Group register: load a new group or shift out the word just moved.
    always_comb begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (s_accept) begin
            ent_next = new_group.ent;
            cnt_next = new_group.cnt;
        end else if (move) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Output word register.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (move) begin
            out_valid_next = 1'b1;
            out_next       = ent_reg[0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.err;

endmodule
